>>> design/cle_pkg.sv
// Package for the cooked line editor: sizes, key codes, command and echo/event types.
`default_nettype none
package cle_pkg;

  localparam int LINE_CAPACITY = 64;
  localparam int CNT_W         = $clog2(LINE_CAPACITY + 1);
  localparam int IDX_W         = $clog2(LINE_CAPACITY);
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] KEY_BS  = 8'h08;
  localparam logic [7:0] KEY_NAK = 8'h15;
  localparam logic [7:0] KEY_ETB = 8'h17;
  localparam logic [7:0] KEY_DEL = 8'h7F;
  localparam logic [7:0] KEY_DC1 = 8'h11;
  localparam logic [7:0] KEY_CR  = 8'h0D;
  localparam logic [7:0] KEY_LF  = 8'h0A;
  localparam logic [7:0] KEY_EOT = 8'h04;
  localparam logic [7:0] KEY_NL  = 8'h0A;

  typedef enum logic [2:0] {
    OP_SCROLL,
    OP_BKSP,
    OP_KILL,
    OP_WORD,
    OP_INTR,
    OP_SEND,
    OP_EOT,
    OP_CHAR
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] key;
  } cmd_t;

  typedef enum logic [2:0] {
    ECHO_NONE,
    ECHO_CHAR,
    ECHO_ERASE,
    ECHO_KILL,
    ECHO_NEWLINE
  } echo_kind_t;

  typedef enum logic [2:0] {
    EV_OTHER,
    EV_SENT,
    EV_INTR,
    EV_SCROLL,
    EV_EOF
  } event_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WORD_RD,
    ST_WORD_CHK,
    ST_WORD_DONE,
    ST_SEND_RD,
    ST_SEND_OUT
  } state_t;

endpackage
`default_nettype wire

>>> design/cooked_line_editor.sv
// Top level of the cooked line editor: front end, command queue and back end.
//
//   Channel  Direction  Handshake               Payload
//   in_      request    in_valid / in_stall     in_key
//   out_     result     out_valid / out_stall   out_echo_kind, out_echo_char,
//                                               out_erase_count, out_send_valid,
//                                               out_send_byte, out_event_res, out_last
//
// Each key is classified in the front end and queued in a two-entry command
// queue, so new requests keep being taken while the back end is busy.
// Single-result keys are loaded into the result register as soon as it is free.
// A word kill reads and then tests each examined byte in turn, because each test
// of the last stored byte waits on the registered read of the line memory.
// A line send reads each sent byte from the line memory, then loads it into the
// result register once that is free, up to 64 bytes per key.
// Reset is synchronous and active low; it empties the line and the queue, and
// the line memory needs no clearing since only written entries are ever read.
// A stall on the result side holds the result register; requests then back up
// into the queue, and in_stall rises only when the queue is full.
`default_nettype none
module cooked_line_editor (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_key,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_echo_kind,
  output logic [7:0]      out_echo_char,
  output logic [6:0]      out_erase_count,
  output logic            out_send_valid,
  output logic [7:0]      out_send_byte,
  output logic [2:0]      out_event_res,
  output logic            out_last
);
  import cle_pkg::*;

  // Commands travel from the classifier into the queue, then to the back end.
  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  cmd_t push_cmd;
  cmd_t head_cmd;

  cle_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_key   (in_key),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  cle_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_push    (q_push),
    .q_cmd_in  (push_cmd),
    .q_full    (q_full),
    .q_pop     (q_pop),
    .q_valid   (q_valid),
    .q_cmd_out (head_cmd)
  );

  // The back end owns the line memory and the result register.
  cle_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_cmd           (head_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_echo_kind   (out_echo_kind),
    .out_echo_char   (out_echo_char),
    .out_erase_count (out_erase_count),
    .out_send_valid  (out_send_valid),
    .out_send_byte   (out_send_byte),
    .out_event_res   (out_event_res),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire

>>> design/cle_front.sv
// Front end: takes key requests and classifies each into an editor command.
`default_nettype none
module cle_front (
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_key,
  input  wire logic          q_full,
  output logic               q_push,
  output cle_pkg::cmd_t      q_cmd
);
  import cle_pkg::*;

  op_t op;

  always_comb begin
    if (in_key[7]) begin
      op = OP_SCROLL;
    end else begin
      case (in_key)
        KEY_BS:                  op = OP_BKSP;
        KEY_NAK:                 op = OP_KILL;
        KEY_ETB:                 op = OP_WORD;
        KEY_DEL:                 op = OP_INTR;
        KEY_DC1, KEY_CR, KEY_LF: op = OP_SEND;
        KEY_EOT:                 op = OP_EOT;
        default:                 op = OP_CHAR;
      endcase
    end
  end

  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;
  assign q_cmd.op  = op;
  assign q_cmd.key = in_key;

endmodule
`default_nettype wire

>>> design/cle_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none
module cle_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_push,
  input  wire cle_pkg::cmd_t q_cmd_in,
  output logic               q_full,
  input  wire logic          q_pop,
  output logic               q_valid,
  output cle_pkg::cmd_t      q_cmd_out
);
  import cle_pkg::*;

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign q_full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid   = (count_r != '0);
  assign q_cmd_out = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (q_push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (q_pop && !q_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      slot_r[wr_ptr_r] <= q_cmd_in;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("command popped from an empty queue");

endmodule
`default_nettype wire

>>> design/cle_back.sv
// Back end: line memory, fill count, scan/send sequencer and result register.
`default_nettype none
module cle_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire cle_pkg::cmd_t q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [2:0]         out_echo_kind,
  output logic [7:0]         out_echo_char,
  output logic [6:0]         out_erase_count,
  output logic               out_send_valid,
  output logic [7:0]         out_send_byte,
  output logic [2:0]         out_event_res,
  output logic               out_last
);
  import cle_pkg::*;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39);
  endfunction

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [CNT_W-1:0]  dropped_r, dropped_nxt;
  logic              phase_r, phase_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [7:0]        key_r, key_nxt;

  logic [7:0]        mem [LINE_CAPACITY];
  logic [7:0]        rd_data_r;
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata;

  logic              out_valid_r, out_valid_nxt;
  echo_kind_t        echo_kind_r, echo_kind_nxt;
  logic [7:0]        echo_char_r, echo_char_nxt;
  logic [6:0]        erase_r, erase_nxt;
  logic              send_valid_r, send_valid_nxt;
  logic [7:0]        send_byte_r, send_byte_nxt;
  event_t            event_r, event_nxt;
  logic              last_r, last_nxt;

  logic              slot_free;
  logic              needs_slot;
  logic              load;
  logic              has_room;
  logic [CNT_W-1:0]  fill_dec;
  logic              send_last;

  assign slot_free  = !out_valid_r || !out_stall;
  assign needs_slot = (q_cmd.op != OP_WORD) && (q_cmd.op != OP_SEND);
  assign q_pop      = (state_r == ST_IDLE) && q_valid && (!needs_slot || slot_free);
  assign has_room   = (fill_r < CNT_W'(LINE_CAPACITY));
  assign fill_dec   = fill_r - 1'b1;
  assign send_last  = ({1'b0, idx_r} == fill_dec);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_pop && q_cmd.op == OP_WORD) begin
          state_nxt = ST_WORD_RD;
        end else if (q_pop && q_cmd.op == OP_SEND) begin
          state_nxt = ST_SEND_RD;
        end
      end
      ST_WORD_RD:   state_nxt = (fill_r == '0) ? ST_WORD_DONE : ST_WORD_CHK;
      ST_WORD_CHK: begin
        if (phase_r && !is_alnum(rd_data_r)) begin
          state_nxt = ST_WORD_DONE;
        end else begin
          state_nxt = ST_WORD_RD;
        end
      end
      ST_WORD_DONE: if (slot_free) state_nxt = ST_IDLE;
      ST_SEND_RD:   state_nxt = ST_SEND_OUT;
      ST_SEND_OUT: begin
        if (slot_free) begin
          state_nxt = send_last ? ST_IDLE : ST_SEND_RD;
        end
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and result register.
  always_comb begin
    fill_nxt       = fill_r;
    dropped_nxt    = dropped_r;
    phase_nxt      = phase_r;
    idx_nxt        = idx_r;
    key_nxt        = key_r;
    mem_we         = 1'b0;
    mem_waddr      = fill_r[IDX_W-1:0];
    mem_wdata      = q_cmd.key;
    mem_re         = 1'b0;
    mem_raddr      = idx_r;
    load           = 1'b0;
    echo_kind_nxt  = echo_kind_r;
    echo_char_nxt  = echo_char_r;
    erase_nxt      = erase_r;
    send_valid_nxt = send_valid_r;
    send_byte_nxt  = send_byte_r;
    event_nxt      = event_r;
    last_nxt       = last_r;

    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          load           = needs_slot;
          echo_kind_nxt  = ECHO_NONE;
          echo_char_nxt  = '0;
          erase_nxt      = '0;
          send_valid_nxt = 1'b0;
          send_byte_nxt  = '0;
          event_nxt      = EV_OTHER;
          last_nxt       = 1'b1;
          case (q_cmd.op)
            OP_SCROLL: event_nxt = EV_SCROLL;
            OP_BKSP: begin
              if (fill_r != '0) fill_nxt = fill_dec;
              echo_kind_nxt = ECHO_ERASE;
              erase_nxt     = 7'd1;
            end
            OP_KILL: begin
              fill_nxt      = '0;
              echo_kind_nxt = ECHO_KILL;
            end
            OP_INTR: begin
              fill_nxt  = '0;
              event_nxt = EV_INTR;
            end
            OP_WORD: begin
              dropped_nxt = '0;
              phase_nxt   = 1'b0;
            end
            OP_SEND: begin
              key_nxt   = q_cmd.key;
              idx_nxt   = '0;
              mem_wdata = KEY_NL;
              if (has_room) begin
                mem_we   = 1'b1;
                fill_nxt = fill_r + 1'b1;
              end
            end
            OP_EOT: begin
              if (fill_r == '0) begin
                event_nxt = EV_EOF;
              end else begin
                echo_kind_nxt = ECHO_CHAR;
                echo_char_nxt = q_cmd.key;
                if (has_room) begin
                  mem_we   = 1'b1;
                  fill_nxt = fill_r + 1'b1;
                end
              end
            end
            OP_CHAR: begin
              echo_kind_nxt = ECHO_CHAR;
              echo_char_nxt = q_cmd.key;
              if (has_room) begin
                mem_we   = 1'b1;
                fill_nxt = fill_r + 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WORD_RD: begin
        mem_re    = (fill_r != '0);
        mem_raddr = fill_dec[IDX_W-1:0];
      end
      ST_WORD_CHK: begin
        if (!phase_r && is_alnum(rd_data_r)) begin
          // Punctuation run is over; the same byte is read again for the word run.
          phase_nxt = 1'b1;
        end else if (!phase_r || is_alnum(rd_data_r)) begin
          fill_nxt    = fill_dec;
          dropped_nxt = dropped_r + 1'b1;
        end
      end
      ST_WORD_DONE: begin
        if (slot_free) begin
          load           = 1'b1;
          echo_kind_nxt  = (dropped_r != '0) ? ECHO_ERASE : ECHO_NONE;
          echo_char_nxt  = '0;
          erase_nxt      = 7'(dropped_r);
          send_valid_nxt = 1'b0;
          send_byte_nxt  = '0;
          event_nxt      = EV_OTHER;
          last_nxt       = 1'b1;
        end
      end
      ST_SEND_RD: begin
        mem_re = 1'b1;
      end
      ST_SEND_OUT: begin
        if (slot_free) begin
          load           = 1'b1;
          echo_kind_nxt  = (idx_r == '0 && key_r != KEY_DC1) ? ECHO_NEWLINE : ECHO_NONE;
          echo_char_nxt  = '0;
          erase_nxt      = '0;
          send_valid_nxt = 1'b1;
          send_byte_nxt  = rd_data_r;
          event_nxt      = EV_SENT;
          last_nxt       = send_last;
          idx_nxt        = idx_r + 1'b1;
          if (send_last) fill_nxt = '0;
        end
      end
      default: ;
    endcase

    out_valid_nxt = load ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dropped_r <= dropped_nxt;
    phase_r   <= phase_nxt;
    idx_r     <= idx_nxt;
    key_r     <= key_nxt;
    if (load) begin
      echo_kind_r  <= echo_kind_nxt;
      echo_char_r  <= echo_char_nxt;
      erase_r      <= erase_nxt;
      send_valid_r <= send_valid_nxt;
      send_byte_r  <= send_byte_nxt;
      event_r      <= event_nxt;
      last_r       <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_echo_kind   = echo_kind_r;
  assign out_echo_char   = echo_char_r;
  assign out_erase_count = erase_r;
  assign out_send_valid  = send_valid_r;
  assign out_send_byte   = send_byte_r;
  assign out_event_res   = event_r;
  assign out_last        = last_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(LINE_CAPACITY))
    else $error("fill count beyond line capacity");

  a_send_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEND_OUT && slot_free && send_last) |=>
      (fill_r == '0 && state_r == ST_IDLE))
    else $error("line not emptied after final sent byte");

  a_word_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WORD_CHK) |=> (fill_r <= $past(fill_r)))
    else $error("word kill scan grew the line");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !send_valid_r) |-> last_r)
    else $error("non-send result without last flag");

endmodule
`default_nettype wire
